>>> rtl/icid_pkg.sv
package icid_pkg;

  // fixed field widths
  localparam int unsigned RING_W    = 13;
  localparam int unsigned UNITS_W   = 5;
  localparam int unsigned UNIT_ID_W = 4;
  localparam int unsigned CTX_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = RING_W;
  localparam int unsigned DIV_CNT_W = $clog2(RING_W);

  localparam logic [RING_W-1:0]  RING_MIN  = RING_W'(2);
  localparam logic [UNITS_W-1:0] UNITS_MIN = UNITS_W'(1);
  localparam logic [UNITS_W-1:0] UNITS_MAX = UNITS_W'(16);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_UNITS = CFG_IDX_W'(1);

  // reset values of the registers
  localparam logic [RING_W-1:0]  RING_SIZE_RST    = RING_W'(4096);
  localparam logic [UNITS_W-1:0] MEMORY_UNITS_RST = UNITS_W'(1);

  // item operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_EMPTY = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_FULL  = STATUS_W'(2);

  typedef struct packed {
    logic             op;
    logic [CTX_W-1:0] ctx_id;
  } icid_item_t;

  typedef struct packed {
    logic [CTX_W-1:0]    ctx_out;
    logic [STATUS_W-1:0] status;
  } icid_result_t;

  // divider control seen by the allocator
  typedef struct packed {
    logic busy;
    logic done;
  } icid_div_sts_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } icid_div_state_e;

endpackage

>>> rtl/icid_ram.sv
module icid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/icid_div.sv
module icid_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [icid_pkg::RING_W-1:0]    dividend_i,
  input  logic [icid_pkg::UNITS_W-1:0]   divisor_i,
  output logic [icid_pkg::RING_W-1:0]    quotient_o,
  output icid_pkg::icid_div_sts_t        sts_o
);

  import icid_pkg::*;

  icid_div_state_e      state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RING_W-1:0]    dq_q, dq_d;
  logic [UNITS_W-1:0]   rem_q, rem_d;
  logic [UNITS_W-1:0]   dvs_q, dvs_d;
  logic                 done_q, done_d;
  logic [UNITS_W:0]     trial;
  logic                 qbit;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dq_q[RING_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    done_d  = 1'b0;
    if (start_i) begin
      state_d = DIV_RUN;
      cnt_d   = '0;
      dq_d    = dividend_i;
      rem_d   = '0;
      dvs_d   = divisor_i;
    end else begin
      unique case (state_q)
        DIV_RUN: begin
          rem_d = qbit ? UNITS_W'(trial - {1'b0, dvs_q}) : trial[UNITS_W-1:0];
          dq_d  = {dq_q[RING_W-2:0], qbit};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(RING_W - 1)) begin
            state_d = DIV_IDLE;
            done_d  = 1'b1;
          end
        end
        default: begin
          state_d = DIV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = dq_q;
  assign sts_o.busy  = (state_q == DIV_RUN);
  assign sts_o.done  = done_q;

endmodule

>>> rtl/interleaved_context_id_allocator.sv
// Context id allocator. An item is either an allocate (op 0) or the return of
// an id (op 1); it is taken at a clock edge with start high and busy low, and
// its one result shows on result_o with done_o high for exactly the next
// cycle, so one item per cycle is sustained while busy stays low. Fresh ids
// come first from a countdown of ring_size / memory_units, rotating the unit
// number into the bits from UNIT_FIELD_SHIFT up; after that, ids come from a
// circular free list held in one synchronous RAM of MAX_CONTEXTS words, read
// in the cycle before the result. After reset and after every register write
// the block reinitializes and computes the countdown start with a bit-serial
// divider; busy stays high meanwhile. The receiver has no way to stall results.
module interleaved_context_id_allocator #(
  parameter int unsigned MAX_CONTEXTS     = 4096,
  parameter int unsigned UNIT_FIELD_SHIFT = 22
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item channel
  input  logic                            start,
  output logic                            busy,
  input  icid_pkg::icid_item_t            item_i,
  output logic                            done_o,
  output icid_pkg::icid_result_t          result_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [icid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [icid_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  import icid_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_CONTEXTS);
  localparam logic [CTX_W-1:0] LOW_MASK =
    CTX_W'((64'd1 << UNIT_FIELD_SHIFT) - 64'd1);

  // configuration registers
  logic [RING_W-1:0]  ring_size_q, ring_size_d;
  logic [UNITS_W-1:0] mem_units_q, mem_units_d;
  logic               cfg_wr;
  logic               cfg_hit;

  // allocator state
  logic [RING_W-1:0]    fresh_q, fresh_d;
  logic [UNIT_ID_W-1:0] unit_q, unit_d;
  logic [POS_W-1:0]     wpos_q, wpos_d;
  logic [POS_W-1:0]     rpos_q, rpos_d;
  logic                 div_start_q, div_start_d;

  // result register; ram data is muxed in for free list pops
  logic         out_valid_q, out_valid_d;
  logic         from_ram_q, from_ram_d;
  icid_result_t out_q, out_d;

  // effective config and derived values
  logic [RING_W-1:0]  len;
  logic [UNITS_W-1:0] units;
  logic [POS_W-1:0]   rpos_inc;
  logic [POS_W-1:0]   wpos_inc;
  logic               list_empty;
  logic               list_full;
  logic [CTX_W-1:0]   fresh_id;
  logic               accept;
  logic               unit_wrap;

  icid_div_sts_t     div_sts;
  logic [RING_W-1:0] div_quot;
  logic              ram_we;
  logic              ram_re;
  logic [CTX_W-1:0]  ram_rdata;

  // clamp ring size to 2..MAX_CONTEXTS and units to 1..16
  always_comb begin
    len = ring_size_q;
    if (ring_size_q < RING_MIN) begin
      len = RING_MIN;
    end else if (32'(ring_size_q) > 32'(MAX_CONTEXTS)) begin
      len = RING_W'(MAX_CONTEXTS);
    end
    units = mem_units_q;
    if (mem_units_q < UNITS_MIN) begin
      units = UNITS_MIN;
    end else if (mem_units_q > UNITS_MAX) begin
      units = UNITS_MAX;
    end
  end

  // ring pointers wrap at the effective length
  assign rpos_inc   = (32'(rpos_q) + 32'd1 == 32'(len)) ? '0 : POS_W'(rpos_q + 1'b1);
  assign wpos_inc   = (32'(wpos_q) + 32'd1 == 32'(len)) ? '0 : POS_W'(wpos_q + 1'b1);
  assign list_empty = (wpos_q == rpos_q);
  assign list_full  = (wpos_inc == rpos_q);

  // fresh id: count minus one below, unit number in its own upper field
  assign fresh_id = (CTX_W'(RING_W'(fresh_q - 1'b1)) & LOW_MASK)
                  | CTX_W'(64'(unit_q) << UNIT_FIELD_SHIFT);
  assign unit_wrap = (UNITS_W'(unit_q) + 1'b1 >= units);

  assign busy   = div_start_q | div_sts.busy | div_sts.done;
  assign accept = start & ~busy;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign cfg_hit     = cfg_wr & ((cfg_index_i == CFG_RING_SIZE) ||
                                 (cfg_index_i == CFG_MEMORY_UNITS));

  assign ram_re = accept & (item_i.op == OP_ALLOC) & (fresh_q == '0) & ~list_empty;
  assign ram_we = accept & (item_i.op == OP_FREE) & ~list_full;

  always_comb begin
    ring_size_d = ring_size_q;
    mem_units_d = mem_units_q;
    fresh_d     = fresh_q;
    unit_d      = unit_q;
    wpos_d      = wpos_q;
    rpos_d      = rpos_q;
    div_start_d = 1'b0;
    out_valid_d = 1'b0;
    from_ram_d  = 1'b0;
    out_d       = out_q;

    if (div_sts.done) begin
      fresh_d = div_quot;
    end

    if (accept) begin
      out_valid_d    = 1'b1;
      out_d.ctx_out  = '0;
      out_d.status   = STAT_OK;
      unique case (item_i.op)
        OP_ALLOC: begin
          priority if (fresh_q != '0) begin
            out_d.ctx_out = fresh_id;
            if (unit_wrap) begin
              fresh_d = fresh_q - 1'b1;
              unit_d  = '0;
            end else begin
              unit_d = unit_q + 1'b1;
            end
          end else if (list_empty) begin
            out_d.ctx_out = CTX_W'(len);
            out_d.status  = STAT_EMPTY;
          end else begin
            // id arrives from the ram read issued this cycle
            from_ram_d = 1'b1;
            rpos_d     = rpos_inc;
          end
        end
        OP_FREE: begin
          if (list_full) begin
            out_d.status = STAT_FULL;
          end else begin
            wpos_d = wpos_inc;
          end
        end
        default: begin
          out_valid_d = 1'b1;
        end
      endcase
    end

    // any register write reinitializes as at reset
    if (cfg_hit) begin
      unique case (cfg_index_i)
        CFG_RING_SIZE:    ring_size_d = cfg_data_i;
        CFG_MEMORY_UNITS: mem_units_d = cfg_data_i[UNITS_W-1:0];
        default:          ring_size_d = ring_size_q;
      endcase
      div_start_d = 1'b1;
      unit_d      = '0;
      wpos_d      = '0;
      rpos_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= RING_SIZE_RST;
      mem_units_q <= MEMORY_UNITS_RST;
      fresh_q     <= '0;
      unit_q      <= '0;
      wpos_q      <= '0;
      rpos_q      <= '0;
      div_start_q <= 1'b1;
      out_valid_q <= 1'b0;
      from_ram_q  <= 1'b0;
    end else begin
      ring_size_q <= ring_size_d;
      mem_units_q <= mem_units_d;
      fresh_q     <= fresh_d;
      unit_q      <= unit_d;
      wpos_q      <= wpos_d;
      rpos_q      <= rpos_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
      from_ram_q  <= from_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // countdown start = effective length / effective unit count
  icid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (len),
    .divisor_i  (units),
    .quotient_o (div_quot),
    .sts_o      (div_sts)
  );

  // free list storage
  icid_ram #(
    .WIDTH (CTX_W),
    .DEPTH (MAX_CONTEXTS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (item_i.ctx_id),
    .re_i    (ram_re),
    .raddr_i (rpos_q),
    .rdata_o (ram_rdata)
  );

  assign done_o           = out_valid_q;
  assign result_o.ctx_out = from_ram_q ? ram_rdata : out_q.ctx_out;
  assign result_o.status  = out_q.status;

`ifndef SYNTH
  // every result answers an item taken in the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without an accepted item");

  // full status only answers a return
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == STAT_FULL) |-> $past(item_i.op == OP_FREE))
    else $error("full status on an allocate");

  // ring pointers stay inside the effective length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(rpos_q) < 32'(len)) && (32'(wpos_q) < 32'(len)))
    else $error("ring pointer out of range");

  // no ram access while reinitializing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !(ram_we || ram_re))
    else $error("ram access while busy");
`endif

endmodule
